### design/bpe_pkg.sv
// Package for the boundary pixel extractor.
// Holds register indexes, fixed field widths and the line store word type.
// No dependencies.
`default_nettype none

package bpe_pkg;

  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int PIXEL_W    = 32;
  localparam int POINT_W    = 10;
  localparam int CELL_IDX_W = 9;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_BOUNDARY_MODE = 2'd2
  } reg_index_t;

  localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RESET  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RESET = 11'd480;
  localparam logic                  MODE_OUTER         = 1'b1;
  localparam logic [CFG_DATA_W-1:0] MIN_DIM            = 11'd3;

  typedef struct packed {
    logic one_up;
    logic two_up;
  } line_bits_t;

endpackage

`default_nettype wire

### design/boundary_pixel_extractor.sv
// Boundary pixel extractor: finds four-neighbor boundary pixels in a raster stream.
// Depends on bpe_pkg and bpe_ram.
//
// Usage:
// Pixels enter on the s_ group, one word per pixel in raster order: tdata holds the
// 32-bit pixel value (nonzero is solid), tuser marks the first pixel of a frame.
// Boundary points leave on the m_ group: tdata holds point_x, point_y and
// cell_index. At most one point leaves per pixel; the point for pixel (x-1,y-1)
// is decided when pixel (x,y) arrives. Border pixels are never reported.
// The block takes one pixel per clock while the output side does not stall. Each
// point is decided in stage one, which holds the line store read, and the
// neighborhood test result is captured in the output register. The two line
// stores share one RAM that is read in the accept cycle and written back when
// stage one advances, with the same-column case forwarded.
// When the receiver stalls, the output register holds its point, the stage in
// front of it holds one more pixel, and then s_tready falls.
// Configuration writes are registered and must be made only while no pixel is in
// flight; the block does not enforce this. Reset clears position, window and handshake
// state; the line stores are not cleared and need two rows before they are read.
`default_nettype none

module boundary_pixel_extractor #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int CELL_SIDE  = 50
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output      logic                             s_tready,
  input  wire logic [bpe_pkg::PIXEL_W-1:0]      s_tdata,  // [31:0] pixel_value
  input  wire logic                             s_tuser,  // [0] frame_start
  output      logic                             m_tvalid,
  input  wire logic                             m_tready,
  output      logic [bpe_pkg::OUT_DATA_W-1:0]   m_tdata,  // [9:0] point_x, [19:10] point_y,
                                                          // [28:20] cell_index, rest zero
  input  wire logic                             cfg_wr_en,
  input  wire logic [bpe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bpe_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import bpe_pkg::*;

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int DW  = $clog2(MAX_WIDTH + 1);
  localparam int DH  = $clog2(MAX_HEIGHT + 1);
  localparam int XCW = $clog2(MAX_WIDTH / CELL_SIDE + 2);
  localparam int YCW = $clog2(MAX_HEIGHT / CELL_SIDE + 2);
  localparam int OW  = $clog2(CELL_SIDE);
  localparam int DN  = $clog2(MAX_WIDTH + CELL_SIDE);
  localparam int RS  = DN + OW;
  localparam int RM  = ((1 << RS) + CELL_SIDE - 1) / CELL_SIDE;
  localparam int MW  = DN + 2;
  localparam int PW  = DN + MW + CELL_IDX_W;
  localparam int PAD = OUT_DATA_W - 2 * POINT_W - CELL_IDX_W;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] image_width;
  logic [CFG_DATA_W-1:0] image_height;
  logic                  boundary_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= IMAGE_WIDTH_RESET;
      image_height  <= IMAGE_HEIGHT_RESET;
      boundary_mode <= MODE_OUTER;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        REG_BOUNDARY_MODE: boundary_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Clamped geometry.
  logic [DW-1:0] w_eff;
  logic [DH-1:0] h_eff;

  always_comb begin
    if (image_width < MIN_DIM) begin
      w_eff = DW'(3);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = DW'(image_width);
    end
    if (image_height < MIN_DIM) begin
      h_eff = DH'(3);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = DH'(MAX_HEIGHT);
    end else begin
      h_eff = DH'(image_height);
    end
  end

  // Cells per row, low bits only, by reciprocal multiplication.
  logic [DN-1:0]         cols_num;
  logic [PW-1:0]         cols_prod;
  logic [CELL_IDX_W-1:0] cells_per_row;

  assign cols_num  = DN'(w_eff) + DN'(CELL_SIDE - 1);
  assign cols_prod = PW'(cols_num) * PW'(RM);

  always_ff @(posedge clk) begin
    cells_per_row <= cols_prod[RS +: CELL_IDX_W];
  end

  // Raster position and grid cell of the next pixel.
  logic [XW-1:0]  column_position;
  logic [YW-1:0]  row_position;
  logic [XCW-1:0] cell_column;
  logic [OW-1:0]  cell_column_offset;
  logic [YCW-1:0] cell_row;
  logic [OW-1:0]  cell_row_offset;

  logic [XW-1:0]  x_cur;
  logic [YW-1:0]  y_cur;
  logic [XCW-1:0] xc_cur;
  logic [OW-1:0]  xo_cur;
  logic [YCW-1:0] yc_cur;
  logic [OW-1:0]  yo_cur;

  logic [XW-1:0]  column_position_next;
  logic [YW-1:0]  row_position_next;
  logic [XCW-1:0] cell_column_next;
  logic [OW-1:0]  cell_column_offset_next;
  logic [YCW-1:0] cell_row_next;
  logic [OW-1:0]  cell_row_offset_next;

  logic           x_wrap;
  logic [DH-1:0]  y_stepped;
  logic           judge_now;
  logic [XCW-1:0] jxc_now;
  logic [YCW-1:0] jyc_now;

  always_comb begin
    if (s_tuser) begin
      x_cur  = '0;
      y_cur  = '0;
      xc_cur = '0;
      xo_cur = '0;
      yc_cur = '0;
      yo_cur = '0;
    end else begin
      x_cur  = column_position;
      y_cur  = row_position;
      xc_cur = cell_column;
      xo_cur = cell_column_offset;
      yc_cur = cell_row;
      yo_cur = cell_row_offset;
    end

    x_wrap = (DW'(x_cur) + DW'(1)) >= w_eff;
    if (x_wrap) begin
      column_position_next    = '0;
      cell_column_next        = '0;
      cell_column_offset_next = '0;
    end else begin
      column_position_next = x_cur + XW'(1);
      if (xo_cur == OW'(CELL_SIDE - 1)) begin
        cell_column_next        = xc_cur + XCW'(1);
        cell_column_offset_next = '0;
      end else begin
        cell_column_next        = xc_cur;
        cell_column_offset_next = xo_cur + OW'(1);
      end
    end

    y_stepped = DH'(y_cur) + DH'(x_wrap);
    if (y_stepped >= h_eff) begin
      row_position_next    = '0;
      cell_row_next        = '0;
      cell_row_offset_next = '0;
    end else if (x_wrap) begin
      row_position_next = YW'(y_stepped);
      if (yo_cur == OW'(CELL_SIDE - 1)) begin
        cell_row_next        = yc_cur + YCW'(1);
        cell_row_offset_next = '0;
      end else begin
        cell_row_next        = yc_cur;
        cell_row_offset_next = yo_cur + OW'(1);
      end
    end else begin
      row_position_next    = y_cur;
      cell_row_next        = yc_cur;
      cell_row_offset_next = yo_cur;
    end

    judge_now = (x_cur >= XW'(2)) && (y_cur >= YW'(2)) &&
                (DW'(x_cur) < w_eff) && (DH'(y_cur) < h_eff);
    jxc_now   = (xo_cur == '0) ? xc_cur - XCW'(1) : xc_cur;
    jyc_now   = (yo_cur == '0) ? yc_cur - YCW'(1) : yc_cur;
  end

  // Pipeline control.
  logic s1_valid;
  logic s1_adv;
  logic accept;

  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !rst && (!s1_valid || s1_adv);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position    <= '0;
      row_position       <= '0;
      cell_column        <= '0;
      cell_column_offset <= '0;
      cell_row           <= '0;
      cell_row_offset    <= '0;
    end else if (accept) begin
      column_position    <= column_position_next;
      row_position       <= row_position_next;
      cell_column        <= cell_column_next;
      cell_column_offset <= cell_column_offset_next;
      cell_row           <= cell_row_next;
      cell_row_offset    <= cell_row_offset_next;
    end
  end

  // Line stores: both rows in one RAM word, read at accept, written from stage one.
  line_bits_t     ram_rdata;
  line_bits_t     ram_wdata;
  line_bits_t     rd_bits;
  logic [XW-1:0]  s1_col;
  logic           s1_solid;
  logic           s1_judge;
  logic [XW-1:0]  s1_x;
  logic [YW-1:0]  s1_y;
  logic [XCW-1:0] s1_xc;
  logic [YCW-1:0] s1_yc;
  logic           fwd;
  line_bits_t     fwd_data;

  bpe_ram #(
    .WIDTH ($bits(line_bits_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (x_cur),
    .rdata (ram_rdata)
  );

  assign rd_bits          = fwd ? fwd_data : ram_rdata;
  assign ram_wdata.one_up = s1_solid;
  assign ram_wdata.two_up = rd_bits.one_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_col   <= x_cur;
      s1_solid <= s_tdata != '0;
      s1_judge <= judge_now;
      s1_x     <= x_cur - XW'(1);
      s1_y     <= y_cur - YW'(1);
      s1_xc    <= jxc_now;
      s1_yc    <= jyc_now;
      fwd      <= s1_adv && (s1_col == x_cur);
      fwd_data <= ram_wdata;
    end
  end

  // Neighborhood window and boundary test.
  logic [8:0]            neighbour_window;
  logic [2:0]            r0;
  logic [2:0]            r1;
  logic [2:0]            r2;
  logic                  hit;
  logic [31:0]           xc_wide;
  logic [31:0]           yc_wide;
  logic [31:0]           px_wide;
  logic [31:0]           py_wide;
  logic [2*CELL_IDX_W-1:0] row_base;
  logic [CELL_IDX_W-1:0] cell_index_next;

  always_comb begin
    r0 = {neighbour_window[1:0], rd_bits.two_up};
    r1 = {neighbour_window[4:3], rd_bits.one_up};
    r2 = {neighbour_window[7:6], s1_solid};
    if (boundary_mode) begin
      hit = !r1[1] && (r1[2] || r1[0] || r0[1] || r2[1]);
    end else begin
      hit = r1[1] && !(r1[2] && r1[0] && r0[1] && r2[1]);
    end
    hit = hit && s1_judge;

    xc_wide  = 32'(s1_xc);
    yc_wide  = 32'(s1_yc);
    px_wide  = 32'(s1_x);
    py_wide  = 32'(s1_y);
    row_base = (2*CELL_IDX_W)'(yc_wide[CELL_IDX_W-1:0]) *
               (2*CELL_IDX_W)'(cells_per_row);
    cell_index_next = row_base[CELL_IDX_W-1:0] + xc_wide[CELL_IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbour_window <= '0;
    end else if (s1_adv) begin
      neighbour_window <= {r2, r1, r0};
    end
  end

  // Output register.
  logic [POINT_W-1:0]    out_x;
  logic [POINT_W-1:0]    out_y;
  logic [CELL_IDX_W-1:0] out_cell;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv && hit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (s1_adv && hit) begin
      out_x    <= px_wide[POINT_W-1:0];
      out_y    <= py_wide[POINT_W-1:0];
      out_cell <= cell_index_next;
    end
  end

  assign m_tdata = {{PAD{1'b0}}, out_cell, out_y, out_x};

endmodule

`default_nettype wire

### design/bpe_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// A read and a write of the same address in one cycle return the old data.
// No dependencies.
`default_nettype none

module bpe_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/bpe_checker.sv
// Port-level checks for the boundary pixel extractor, bound to its top level.
// Depends on bpe_pkg and boundary_pixel_extractor.
`default_nettype none

module bpe_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [bpe_pkg::OUT_DATA_W-1:0] m_tdata
);

  import bpe_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Output word changed or dropped while stalled.");

  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("Input stalled while the output register is empty.");

  a_rise_after_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("Output word without a pixel taken two cycles earlier.");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("Output valid right after reset.");

endmodule

bind boundary_pixel_extractor bpe_checker u_bpe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

### tb/boundary_pixel_extractor_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for boundary_pixel_extractor: streams pixel frames, predicts
// the boundary points in a local model and checks every point word the block returns.
// Depends on bpe_pkg and the boundary_pixel_extractor RTL.

module boundary_pixel_extractor_test;
  import bpe_pkg::*;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int CELL = 50;
  localparam logic MODE_INNER = ~MODE_OUTER;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [PIXEL_W-1:0] value;
    logic start;
  } pixel_word_t;

  typedef struct {
    logic [POINT_W-1:0] x;
    logic [POINT_W-1:0] y;
    logic [CELL_IDX_W-1:0] cell_idx;
  } boundary_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [PIXEL_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic cfg_wr_en = 1'b0;
  reg_index_t cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pixel_word_t pending_pixels[$];
  boundary_point_t expected_points[$];

  // Shadow of the configuration and of the block's raster state.
  logic [CFG_DATA_W-1:0] width_setting = IMAGE_WIDTH_RESET;
  logic [CFG_DATA_W-1:0] height_setting = IMAGE_HEIGHT_RESET;
  logic mode_setting = MODE_OUTER;
  bit one_up_bits[MAX_COLS];
  bit two_up_bits[MAX_COLS];
  bit written_once[MAX_COLS];
  logic [8:0] nbhd = '0;
  int unsigned next_col = 0;
  int unsigned next_row = 0;
  int unsigned cols_written = 0;

  int mismatch_count = 0;
  int cycle_count = 0;
  bit sender_idles = 1'b0;
  bit receiver_stalls = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_requests = 0;
  int holds_seen = 0;

  boundary_pixel_extractor #(
    .MAX_WIDTH(MAX_COLS),
    .MAX_HEIGHT(MAX_ROWS),
    .CELL_SIDE(CELL)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned effective_dim(logic [CFG_DATA_W-1:0] v, int unsigned hi);
    if (v < MIN_DIM) return 32'(MIN_DIM);
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic void predict_boundary(logic [PIXEL_W-1:0] value, logic start);
    int unsigned w, h, x, y, c, cols;
    logic solid, hit;
    logic [2:0] r0, r1, r2;
    boundary_point_t pt;
    w = effective_dim(width_setting, MAX_COLS);
    h = effective_dim(height_setting, MAX_ROWS);
    solid = (value != '0);
    if (start) begin
      next_col = 0;
      next_row = 0;
    end
    x = next_col;
    y = next_row;
    c = x % MAX_COLS;
    r0 = {nbhd[1:0], two_up_bits[c]};
    r1 = {nbhd[4:3], one_up_bits[c]};
    r2 = {nbhd[7:6], solid};
    nbhd = {r2, r1, r0};
    two_up_bits[c] = one_up_bits[c];
    one_up_bits[c] = solid;
    if (written_once[c] && c + 1 > cols_written) cols_written = c + 1;
    written_once[c] = 1'b1;
    if (x >= 2 && y >= 2 && x - 1 <= w - 2 && y - 1 <= h - 2) begin
      if (mode_setting == MODE_OUTER) begin
        hit = !r1[1] && (r1[2] | r1[0] | r0[1] | r2[1]);
      end else begin
        hit = r1[1] && !(r1[2] & r1[0] & r0[1] & r2[1]);
      end
      if (hit) begin
        cols = (w + CELL - 1) / CELL;
        pt.x = POINT_W'(x - 1);
        pt.y = POINT_W'(y - 1);
        pt.cell_idx = CELL_IDX_W'(((y - 1) / CELL) * cols + (x - 1) / CELL);
        expected_points.insert(expected_points.size(), pt);
      end
    end
    x++;
    if (x >= w) begin
      x = 0;
      y++;
    end
    if (y >= h) y = 0;
    next_col = x;
    next_row = y;
  endfunction

  function automatic logic [PIXEL_W-1:0] draw_pixel(int density);
    if ($urandom_range(0, 99) >= density) return '0;
    case ($urandom_range(0, 3))
      0: return 32'h1 << $urandom_range(0, 31);
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_pixels.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (sender_idles && $urandom_range(0, 4) == 0) begin
        gap_left <= $urandom_range(0, 5);
        s_tvalid <= 1'b0;
      end else begin
        s_tdata <= pending_pixels[0].value;
        s_tuser <= pending_pixels[0].start;
        s_tvalid <= 1'b1;
        void'(pending_pixels.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (holds_seen != hold_requests) begin
      holds_seen <= hold_requests;
      stall_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 5);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    boundary_point_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) predict_boundary(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        if (expected_points.size() == 0) begin
          $display("%0t: expected no point word, got x=%0d y=%0d cell=%0d", $time,
                   m_tdata[9:0], m_tdata[19:10], m_tdata[28:20]);
          mismatch_count++;
        end else begin
          want = expected_points.pop_front();
          if (m_tdata[9:0] !== want.x || m_tdata[19:10] !== want.y ||
              m_tdata[28:20] !== want.cell_idx || m_tdata[31:29] !== 3'b000) begin
            $display(
              "%0t: expected x=%0d y=%0d cell=%0d pad=0, got x=%0d y=%0d cell=%0d pad=%0h",
              $time, want.x, want.y, want.cell_idx,
              m_tdata[9:0], m_tdata[19:10], m_tdata[28:20], m_tdata[31:29]);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d points outstanding", $time, expected_points.size());
      $display("boundary_pixel_extractor test failed");
      $finish;
    end
  end

  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_IMAGE_WIDTH: width_setting = value;
      REG_IMAGE_HEIGHT: height_setting = value;
      REG_BOUNDARY_MODE: mode_setting = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] w_set, logic [CFG_DATA_W-1:0] h_set,
                           logic mode);
    write_reg(REG_IMAGE_WIDTH, w_set);
    write_reg(REG_IMAGE_HEIGHT, h_set);
    write_reg(REG_BOUNDARY_MODE, {{(CFG_DATA_W-1){1'b0}}, mode});
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    while (pending_pixels.size() != 0 || s_tvalid || expected_points.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A 3x3 frame; bit i of the map makes raster pixel i solid.
  task automatic push_frame_3x3(logic [8:0] solid_map);
    pixel_word_t word;
    for (int i = 0; i < 9; i++) begin
      word.value = solid_map[i] ? (32'h1 << (3 * i)) | 32'h8000_0000 : '0;
      word.start = (i == 0);
      pending_pixels.insert(pending_pixels.size(), word);
    end
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] w_set, logic [CFG_DATA_W-1:0] h_set,
                           logic mode, int count, int density, bit fresh, bit idling,
                           bit long_hold);
    int frame_len;
    pixel_word_t word;
    configure(w_set, h_set, mode);
    frame_len = effective_dim(w_set, MAX_COLS) * effective_dim(h_set, MAX_ROWS);
    @(negedge clk);
    sender_idles = idling;
    receiver_stalls = idling;
    if (long_hold) hold_requests++;
    for (int k = 0; k < count; k++) begin
      word.value = draw_pixel(density);
      word.start = (fresh && k % frame_len == 0) || $urandom_range(0, 99) == 0;
      pending_pixels.insert(pending_pixels.size(), word);
    end
    wait_quiet();
  endtask

  initial begin
    int random_items;
    int count;
    int unsigned we, he;
    logic [CFG_DATA_W-1:0] w_set, h_set;
    logic mode;
    bit fresh;
    random_items = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Smallest image, reached through clamping of the width and height.
    configure(11'd2, 11'd1, MODE_OUTER);
    @(negedge clk);
    push_frame_3x3(9'b000_000_010);
    push_frame_3x3(9'b000_010_000);
    wait_quiet();
    configure(11'd2, 11'd1, MODE_INNER);
    @(negedge clk);
    push_frame_3x3(9'b111_011_111);
    wait_quiet();

    run_phase(11'd20, 11'd20, MODE_OUTER, 400, 35, 1'b1, 1'b1, 1'b1);
    run_phase(11'd0, 11'd2047, MODE_INNER, 90, 60, 1'b1, 1'b1, 1'b0);

    while (random_items < 450) begin
      case ($urandom_range(0, 11))
        0: w_set = CFG_DATA_W'($urandom_range(0, 2));
        1: w_set = CFG_DATA_W'($urandom_range(1025, 2047));
        default: w_set = CFG_DATA_W'($urandom_range(3, 120));
      endcase
      h_set = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                          : CFG_DATA_W'($urandom_range(3, 9));
      mode = ($urandom_range(0, 1) == 1) ? MODE_OUTER : MODE_INNER;
      we = effective_dim(w_set, MAX_COLS);
      he = effective_dim(h_set, MAX_ROWS);
      // A frame may carry on across a setting change as long as every column it
      // reads has been written at least twice since reset.
      fresh = !($urandom_range(0, 3) == 0 && we <= cols_written);
      count = we * he * $urandom_range(1, 2) + $urandom_range(0, we);
      if (count > 400) count = 400;
      run_phase(w_set, h_set, mode, count, $urandom_range(5, 95), fresh,
                random_items < 330 && $urandom_range(0, 3) != 0, 1'b0);
      random_items += count;
    end

    if (mismatch_count == 0) begin
      $display("boundary_pixel_extractor test passed");
    end else begin
      $display("boundary_pixel_extractor test failed");
    end
    $finish;
  end

endmodule
